// File: hdl/rtav_pkg.sv
// Shared types, constants and helper functions for the rotation-to-viewpoint block.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package rtav_pkg;

   // transaction payloads
   typedef struct packed {
      logic signed [15:0] mat_0_0;
      logic signed [15:0] mat_0_1;
      logic signed [15:0] mat_0_2;
      logic signed [15:0] mat_1_0;
      logic signed [15:0] mat_1_1;
      logic signed [15:0] mat_1_2;
      logic signed [15:0] mat_2_0;
      logic signed [15:0] mat_2_1;
      logic signed [15:0] mat_2_2;
   } req_type;

   typedef struct packed {
      logic signed [15:0] axis_x;
      logic signed [15:0] axis_y;
      logic signed [15:0] axis_z;
      logic        [15:0] angle;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic               axis_default;
   } rsp_type;

   // register map (word index)
   typedef enum logic [2:0] {
      REG_TRANS_X  = 3'd0,
      REG_TRANS_Y  = 3'd1,
      REG_TRANS_Z  = 3'd2,
      REG_CENTER_X = 3'd3,
      REG_CENTER_Y = 3'd4,
      REG_CENTER_Z = 3'd5
   } reg_idx_type;

   localparam int CSR_AW = 5;
   localparam logic signed [31:0] TRANS_Z_RESET = 32'sd7208960;

   // pipeline
   localparam int PIPE_DEPTH   = 52;
   localparam int AX_SQ_STEPS  = 31;   // root of a 62-bit value
   localparam int AN_SQ_STEPS  = 16;   // root of a 32-bit value
   localparam int QW           = 16;   // axis quotient bits
   localparam int NUMW         = 46;   // axis dividend
   localparam int DENW         = 32;   // axis divisor
   localparam int CORDIC_STEPS = 20;
   localparam int XW           = 34;   // CORDIC x/y
   localparam int ZW           = 24;   // CORDIC angle, Q.20

   localparam logic signed [18:0] TRACE_BIAS = 19'sd16384;
   localparam logic signed [18:0] TRACE_LIM  = 19'sd32768;
   localparam logic        [30:0] ONE_SQ     = 31'd1073741824;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 24'sd1647099;
   localparam logic        [15:0] ANGLE_MAX  = 16'd51472;
   localparam logic        [15:0] AXIS_ONE   = 16'd16384;

   localparam logic signed [ZW-1:0] ATAN_TAB [10] = '{
      24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
      24'sd32757, 24'sd16383, 24'sd8192, 24'sd4096, 24'sd2048
   };

   // arctan(2^-i) in Q.20; past the table it is just 2^(20-i)
   function automatic logic signed [ZW-1:0] cordic_step(input int idx);
      logic signed [ZW-1:0] val;
      if (idx < 10) begin
         val = ATAN_TAB[idx];
      end else begin
         val = ZW'(1) << (CORDIC_STEPS - idx);
      end
      return val;
   endfunction

endpackage

`default_nettype wire

// File: hdl/rtav_delay.sv
// Enabled shift line used to line up side values with the arithmetic chains.
// Standalone; no package use.
`default_nettype none

module rtav_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [W-1:0] d_i,
   output logic      [W-1:0] q_o
);

   logic [W-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d_i;
      end
   end

   for (genvar i = 1; i < DEPTH; i++) begin : g_tap
      always_ff @(posedge clock) begin
         if (en) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q_o = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// File: hdl/rtav_sqrt_cell.sv
// One digit of a restoring integer square root: two radicand bits in, one root bit out.
// Standalone; chained by the top level.
`default_nettype none

module rtav_sqrt_cell #(
   parameter int NW = 32,
   parameter int RW = NW / 2
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [RW+1:0] rem_i,
   input  wire logic [RW-1:0] root_i,
   input  wire logic [NW-1:0] rest_i,
   output logic      [RW+1:0] rem_o,
   output logic      [RW-1:0] root_o,
   output logic      [NW-1:0] rest_o
);

   logic [RW+3:0] rem2;
   logic [RW+3:0] trial;
   logic [RW+3:0] diff;
   logic          ge;
   logic [RW+1:0] rem_in,  rem_ff;
   logic [RW-1:0] root_in, root_ff;
   logic [NW-1:0] rest_in, rest_ff;

   always_comb begin
      rem2    = {rem_i, rest_i[NW-1 -: 2]};
      trial   = {2'b00, root_i, 2'b01};
      diff    = rem2 - trial;
      ge      = (rem2 >= trial);
      rem_in  = ge ? diff[RW+1:0] : rem2[RW+1:0];
      root_in = {root_i[RW-2:0], ge};
      rest_in = {rest_i[NW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rest_ff <= rest_in;
      end
   end

   assign rem_o  = rem_ff;
   assign root_o = root_ff;
   assign rest_o = rest_ff;

endmodule

`default_nettype wire

// File: hdl/rtav_div_cell.sv
// One quotient bit of a restoring divider (bit K), used for axis normalization.
// Standalone; chained by the top level.
`default_nettype none

module rtav_div_cell #(
   parameter int NW = 46,
   parameter int DW = 32,
   parameter int QW = 16,
   parameter int K  = 0
) (
   input  wire logic          clock,
   input  wire logic          en,
   input  wire logic [NW-1:0] rem_i,
   input  wire logic [DW-1:0] den_i,
   input  wire logic [QW-1:0] quo_i,
   output logic      [NW-1:0] rem_o,
   output logic      [DW-1:0] den_o,
   output logic      [QW-1:0] quo_o
);

   localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

   logic [CW-1:0] shd;
   logic [CW-1:0] diff;
   logic          ge;
   logic [NW-1:0] rem_in, rem_ff;
   logic [DW-1:0] den_ff;
   logic [QW-1:0] quo_in, quo_ff;

   always_comb begin
      shd    = CW'(den_i) << K;
      diff   = CW'(rem_i) - shd;
      ge     = (CW'(rem_i) >= shd);
      rem_in = ge ? diff[NW-1:0] : rem_i;
      quo_in = quo_i | (QW'(ge) << K);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= den_i;
         quo_ff <= quo_in;
      end
   end

   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign quo_o = quo_ff;

endmodule

`default_nettype wire

// File: hdl/rtav_cordic_cell.sv
// One vectoring-mode CORDIC iteration (step IDX), floor shifts.
// Depends on rtav_pkg for widths and the arctangent steps.
`default_nettype none

module rtav_cordic_cell #(
   parameter int IDX = 0
) (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic signed [rtav_pkg::XW-1:0] x_i,
   input  wire logic signed [rtav_pkg::XW-1:0] y_i,
   input  wire logic signed [rtav_pkg::ZW-1:0] z_i,
   output logic      signed [rtav_pkg::XW-1:0] x_o,
   output logic      signed [rtav_pkg::XW-1:0] y_o,
   output logic      signed [rtav_pkg::ZW-1:0] z_o
);

   localparam logic signed [rtav_pkg::ZW-1:0] STEP = rtav_pkg::cordic_step(IDX);

   logic signed [rtav_pkg::XW-1:0] xs, ys;
   logic signed [rtav_pkg::XW-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [rtav_pkg::ZW-1:0] z_in, z_ff;

   always_comb begin
      xs = x_i >>> IDX;
      ys = y_i >>> IDX;
      if (!y_i[rtav_pkg::XW-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + STEP;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;

endmodule

`default_nettype wire

// File: hdl/rotation_to_axis_angle_viewpoint.sv
// Top level: rotation matrix to viewpoint axis, angle and position.
// Depends on rtav_pkg, rtav_delay, rtav_sqrt_cell, rtav_div_cell, rtav_cordic_cell.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | rtav_pkg::req_type
//   rsp     | out       | rsp_valid/rsp_stall  | rtav_pkg::rsp_type
//   csr     | in/out    | APB, pready tied high| six 32-bit registers
//
// One transaction per cycle through 52 register stages, unless a stalled result
// freezes the pipeline. The latency is set by the axis path: 31 square-root
// cells, then 16 divider cells.
// Synchronous reset empties the pipeline and restores the registers.
// A stalled result freezes the whole pipeline; req_stall follows in the same cycle.
`default_nettype none

module rotation_to_axis_angle_viewpoint (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire rtav_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rtav_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [rtav_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [31:0]                   csr_pwdata,
   output logic      [31:0]                   csr_prdata,
   output logic                               csr_pready
);

   localparam int L = rtav_pkg::PIPE_DEPTH;

   // ---------------- registers ----------------
   logic signed [31:0] trans_ff [3];
   logic signed [31:0] center_ff [3];
   rtav_pkg::reg_idx_type csr_idx;
   logic csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = rtav_pkg::reg_idx_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trans_ff[0]  <= '0;
         trans_ff[1]  <= '0;
         trans_ff[2]  <= rtav_pkg::TRANS_Z_RESET;
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rtav_pkg::REG_TRANS_X:  trans_ff[0]  <= csr_pwdata;
            rtav_pkg::REG_TRANS_Y:  trans_ff[1]  <= csr_pwdata;
            rtav_pkg::REG_TRANS_Z:  trans_ff[2]  <= csr_pwdata;
            rtav_pkg::REG_CENTER_X: center_ff[0] <= csr_pwdata;
            rtav_pkg::REG_CENTER_Y: center_ff[1] <= csr_pwdata;
            rtav_pkg::REG_CENTER_Z: center_ff[2] <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rtav_pkg::REG_TRANS_X:  csr_prdata = trans_ff[0];
         rtav_pkg::REG_TRANS_Y:  csr_prdata = trans_ff[1];
         rtav_pkg::REG_TRANS_Z:  csr_prdata = trans_ff[2];
         rtav_pkg::REG_CENTER_X: csr_prdata = center_ff[0];
         rtav_pkg::REG_CENTER_Y: csr_prdata = center_ff[1];
         rtav_pkg::REG_CENTER_Z: csr_prdata = center_ff[2];
         default:                csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   logic       en;
   logic [L:1] vld_ff;
   logic [L:1] vld_in;

   assign en        = !(vld_ff[L] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[L];
   assign vld_in    = {vld_ff[L-1:1], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // ---------------- stage 1 ----------------
   logic signed [15:0] mrow [3][3];
   logic signed [32:0] ntr [3];
   logic signed [16:0] d_in [3], d_ff [3];
   logic signed [18:0] t_in, t1_ff;
   logic signed [48:0] prod_in [3][3], prod_ff [3][3];
   logic signed [45:0] cen_in [3], cen_ff [3];
   logic [16:0] mag1 [3];
   logic [2:0]  sgn1;

   always_comb begin
      mrow[0][0] = req_data.mat_0_0; mrow[0][1] = req_data.mat_0_1;
      mrow[0][2] = req_data.mat_0_2; mrow[1][0] = req_data.mat_1_0;
      mrow[1][1] = req_data.mat_1_1; mrow[1][2] = req_data.mat_1_2;
      mrow[2][0] = req_data.mat_2_0; mrow[2][1] = req_data.mat_2_1;
      mrow[2][2] = req_data.mat_2_2;
      d_in[0] = 17'(req_data.mat_2_1) - 17'(req_data.mat_1_2);
      d_in[1] = 17'(req_data.mat_0_2) - 17'(req_data.mat_2_0);
      d_in[2] = 17'(req_data.mat_1_0) - 17'(req_data.mat_0_1);
      t_in = 19'(req_data.mat_0_0) + 19'(req_data.mat_1_1) + 19'(req_data.mat_2_2)
           - rtav_pkg::TRACE_BIAS;
      for (int j = 0; j < 3; j++) begin
         ntr[j] = -(33'(trans_ff[j]));
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = 49'(mrow[i][j]) * 49'(ntr[j]);
         end
         cen_in[i] = $signed({center_ff[i], 14'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff    <= d_in;
         t1_ff   <= t_in;
         prod_ff <= prod_in;
         cen_ff  <= cen_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag1[k] = d_ff[k][16] ? 17'(-d_ff[k]) : 17'(d_ff[k]);
         sgn1[k] = d_ff[k][16];
      end
   end

   // ---------------- stage 2 ----------------
   logic [33:0] sq_in [3], sq_ff [3];
   logic [36:0] tt_in, tt_ff;
   logic        inr_in, inr2_ff;
   logic signed [18:0] t2_ff;
   logic signed [51:0] acc_in [3], acc_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = $unsigned(34'(d_ff[k]) * 34'(d_ff[k]));
      end
      tt_in  = $unsigned(37'(t1_ff) * 37'(t1_ff));
      inr_in = (t1_ff >= -rtav_pkg::TRACE_LIM) && (t1_ff <= rtav_pkg::TRACE_LIM);
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = 52'(prod_ff[i][0]) + 52'(prod_ff[i][1]) + 52'(prod_ff[i][2])
                   - 52'(cen_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff   <= sq_in;
         tt_ff   <= tt_in;
         inr2_ff <= inr_in;
         t2_ff   <= t1_ff;
         acc_ff  <= acc_in;
      end
   end

   // ---------------- stage 3 ----------------
   logic [33:0] s_in, s3_ff;
   logic [30:0] n_in, n3_ff;
   logic        inr3_ff;
   logic signed [18:0] t3_ff;
   logic signed [51:0] rnd [3];
   logic signed [31:0] pos_in [3], pos3_ff [3];

   always_comb begin
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      n_in = inr2_ff ? (rtav_pkg::ONE_SQ - tt_ff[30:0]) : '0;
      for (int i = 0; i < 3; i++) begin
         rnd[i] = (acc_ff[i] + 52'sd8192) >>> 14;
         if (rnd[i] > 52'sd2147483647) begin
            pos_in[i] = 32'sh7fffffff;
         end else if (rnd[i] < -52'sd2147483648) begin
            pos_in[i] = 32'sh80000000;
         end else begin
            pos_in[i] = rnd[i][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ff   <= s_in;
         n3_ff   <= n_in;
         inr3_ff <= inr2_ff;
         t3_ff   <= t2_ff;
         pos3_ff <= pos_in;
      end
   end

   // ---------------- side delays ----------------
   logic [16:0] mag34 [3];
   logic [2:0]  sgn51;
   logic        zero51;
   logic [95:0] pos51;
   logic [18:0] t19;
   logic        inr40;

   for (genvar k = 0; k < 3; k++) begin : g_mag
      rtav_delay #(.W(17), .DEPTH(33)) u_mag (
         .clock(clock), .en(en), .d_i(mag1[k]), .q_o(mag34[k]));
   end

   rtav_delay #(.W(3), .DEPTH(50)) u_sgn (
      .clock(clock), .en(en), .d_i(sgn1), .q_o(sgn51));
   rtav_delay #(.W(1), .DEPTH(48)) u_zero (
      .clock(clock), .en(en), .d_i(s3_ff == '0), .q_o(zero51));
   rtav_delay #(.W(96), .DEPTH(48)) u_pos (
      .clock(clock), .en(en), .d_i({pos3_ff[0], pos3_ff[1], pos3_ff[2]}), .q_o(pos51));
   rtav_delay #(.W(19), .DEPTH(16)) u_t (
      .clock(clock), .en(en), .d_i(t3_ff), .q_o(t19));
   rtav_delay #(.W(1), .DEPTH(37)) u_inr (
      .clock(clock), .en(en), .d_i(inr3_ff), .q_o(inr40));

   // ---------------- axis length: square root of S * 2^28 ----------------
   localparam int AXN = 2 * rtav_pkg::AX_SQ_STEPS;
   localparam int AXR = rtav_pkg::AX_SQ_STEPS;

   logic [AXR+1:0] ax_rem  [rtav_pkg::AX_SQ_STEPS+1];
   logic [AXR-1:0] ax_root [rtav_pkg::AX_SQ_STEPS+1];
   logic [AXN-1:0] ax_rest [rtav_pkg::AX_SQ_STEPS+1];

   assign ax_rem[0]  = '0;
   assign ax_root[0] = '0;
   assign ax_rest[0] = {s3_ff, 28'd0};

   for (genvar c = 0; c < rtav_pkg::AX_SQ_STEPS; c++) begin : g_axsq
      rtav_sqrt_cell #(.NW(AXN), .RW(AXR)) u_cell (
         .clock(clock), .en(en),
         .rem_i(ax_rem[c]), .root_i(ax_root[c]), .rest_i(ax_rest[c]),
         .rem_o(ax_rem[c+1]), .root_o(ax_root[c+1]), .rest_o(ax_rest[c+1]));
   end

   // ---------------- stage 35: dividend and divisor ----------------
   logic [rtav_pkg::NUMW-1:0] num35_ff [3];
   logic [rtav_pkg::DENW-1:0] den35_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            // 2*|d|*2^28 + r, rounds half away from zero after division by 2r
            num35_ff[k] <= {mag34[k], 29'd0} + rtav_pkg::NUMW'(ax_root[AXR]);
         end
         den35_ff <= {ax_root[AXR], 1'b0};
      end
   end

   // ---------------- axis divider lanes ----------------
   logic [rtav_pkg::NUMW-1:0] dv_rem [3][rtav_pkg::QW+1];
   logic [rtav_pkg::DENW-1:0] dv_den [3][rtav_pkg::QW+1];
   logic [rtav_pkg::QW-1:0]   dv_quo [3][rtav_pkg::QW+1];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      assign dv_rem[k][0] = num35_ff[k];
      assign dv_den[k][0] = den35_ff;
      assign dv_quo[k][0] = '0;
      for (genvar c = 0; c < rtav_pkg::QW; c++) begin : g_div
         rtav_div_cell #(
            .NW(rtav_pkg::NUMW), .DW(rtav_pkg::DENW), .QW(rtav_pkg::QW),
            .K(rtav_pkg::QW - 1 - c)
         ) u_cell (
            .clock(clock), .en(en),
            .rem_i(dv_rem[k][c]), .den_i(dv_den[k][c]), .quo_i(dv_quo[k][c]),
            .rem_o(dv_rem[k][c+1]), .den_o(dv_den[k][c+1]), .quo_o(dv_quo[k][c+1]));
      end
   end

   // ---------------- angle: sin term, square root of 2^30 - t^2 ----------------
   localparam int ANN = 2 * rtav_pkg::AN_SQ_STEPS;
   localparam int ANR = rtav_pkg::AN_SQ_STEPS;

   logic [ANR+1:0] an_rem  [rtav_pkg::AN_SQ_STEPS+1];
   logic [ANR-1:0] an_root [rtav_pkg::AN_SQ_STEPS+1];
   logic [ANN-1:0] an_rest [rtav_pkg::AN_SQ_STEPS+1];

   assign an_rem[0]  = '0;
   assign an_root[0] = '0;
   assign an_rest[0] = ANN'(n3_ff);

   for (genvar c = 0; c < rtav_pkg::AN_SQ_STEPS; c++) begin : g_ansq
      rtav_sqrt_cell #(.NW(ANN), .RW(ANR)) u_cell (
         .clock(clock), .en(en),
         .rem_i(an_rem[c]), .root_i(an_root[c]), .rest_i(an_rest[c]),
         .rem_o(an_rem[c+1]), .root_o(an_root[c+1]), .rest_o(an_rest[c+1]));
   end

   // ---------------- stage 20: CORDIC start, pre-turn for t < 0 ----------------
   logic signed [rtav_pkg::XW-1:0] x0, y0;
   logic signed [rtav_pkg::XW-1:0] cx [rtav_pkg::CORDIC_STEPS+1];
   logic signed [rtav_pkg::XW-1:0] cy [rtav_pkg::CORDIC_STEPS+1];
   logic signed [rtav_pkg::ZW-1:0] cz [rtav_pkg::CORDIC_STEPS+1];
   logic signed [rtav_pkg::XW-1:0] x20_in, x20_ff, y20_in, y20_ff;
   logic signed [rtav_pkg::ZW-1:0] z20_in, z20_ff;

   always_comb begin
      x0 = rtav_pkg::XW'($signed(t19)) <<< 15;
      y0 = $signed(rtav_pkg::XW'(an_root[ANR])) <<< 15;
      if (t19[18]) begin
         x20_in = y0;
         y20_in = -x0;
         z20_in = rtav_pkg::ANG_HALF_PI;
      end else begin
         x20_in = x0;
         y20_in = y0;
         z20_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x20_ff <= x20_in;
         y20_ff <= y20_in;
         z20_ff <= z20_in;
      end
   end

   assign cx[0] = x20_ff;
   assign cy[0] = y20_ff;
   assign cz[0] = z20_ff;

   for (genvar c = 0; c < rtav_pkg::CORDIC_STEPS; c++) begin : g_cordic
      rtav_cordic_cell #(.IDX(c)) u_cell (
         .clock(clock), .en(en),
         .x_i(cx[c]), .y_i(cy[c]), .z_i(cz[c]),
         .x_o(cx[c+1]), .y_o(cy[c+1]), .z_o(cz[c+1]));
   end

   // ---------------- stage 41: angle rounding ----------------
   logic [rtav_pkg::ZW-1:0] zpos, zsum, zq;
   logic [15:0] ang_in, ang41_ff, ang51;

   always_comb begin
      zpos = cz[rtav_pkg::CORDIC_STEPS][rtav_pkg::ZW-1] ? '0 : cz[rtav_pkg::CORDIC_STEPS];
      zsum = zpos + rtav_pkg::ZW'(32);
      zq   = zsum >> 6;
      if (!inr40) begin
         ang_in = '0;
      end else if (zq > rtav_pkg::ZW'(rtav_pkg::ANGLE_MAX)) begin
         ang_in = rtav_pkg::ANGLE_MAX;
      end else begin
         ang_in = zq[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ang41_ff <= ang_in;
      end
   end

   rtav_delay #(.W(16), .DEPTH(10)) u_ang (
      .clock(clock), .en(en), .d_i(ang41_ff), .q_o(ang51));

   // ---------------- stage 52: result register ----------------
   logic [15:0]        qc [3];
   logic signed [15:0] ax [3];
   rtav_pkg::rsp_type  rsp_in, rsp_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         qc[k] = (dv_quo[k][rtav_pkg::QW] > rtav_pkg::AXIS_ONE) ? rtav_pkg::AXIS_ONE
                                                                : dv_quo[k][rtav_pkg::QW];
         ax[k] = sgn51[k] ? -$signed(qc[k]) : $signed(qc[k]);
      end
      rsp_in.axis_x       = zero51 ? '0 : ax[0];
      rsp_in.axis_y       = zero51 ? '0 : ax[1];
      rsp_in.axis_z       = zero51 ? $signed(rtav_pkg::AXIS_ONE) : ax[2];
      rsp_in.angle        = ang51;
      rsp_in.pos_x        = pos51[95:64];
      rsp_in.pos_y        = pos51[63:32];
      rsp_in.pos_z        = pos51[31:0];
      rsp_in.axis_default = zero51;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/rtav_checker.sv
// Port-level checks for the rotation-to-viewpoint top level, bound below.
// Depends on rtav_pkg.
`default_nettype none

module rtav_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire rtav_pkg::req_type           req_data,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire rtav_pkg::rsp_type           rsp_data,
   input wire logic                        csr_psel,
   input wire logic                        csr_penable,
   input wire logic                        csr_pwrite,
   input wire logic [rtav_pkg::CSR_AW-1:0] csr_paddr,
   input wire logic [31:0]                 csr_pwdata,
   input wire logic [31:0]                 csr_prdata,
   input wire logic                        csr_pready
);

   // a stalled transaction stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction changed while stalled");

   // a blocked result must back-pressure the input in the same cycle
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input accepted while the pipeline is frozen");

   a_default_axis: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.axis_default |->
         rsp_data.axis_x == 16'sd0 && rsp_data.axis_y == 16'sd0 &&
         rsp_data.axis_z == $signed(rtav_pkg::AXIS_ONE))
      else $error("fallback axis is not +z");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.angle <= rtav_pkg::ANGLE_MAX)
      else $error("angle above pi");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result out of an empty pipeline");

endmodule

bind rotation_to_axis_angle_viewpoint rtav_checker u_rtav_checker (.*);

`default_nettype wire
